>>> sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int IDX_W    = 12;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 13;
  localparam int BITSEL_W = 6;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  block_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    granted_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  used_count;
  } rsp_t;

  // group and bit position of a block index, from the splitter
  typedef struct packed {
    logic                done;
    logic [IDX_W-1:0]    group;
    logic [BITSEL_W-1:0] bit_idx;
  } split_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_READ,
    ST_CHECK,
    ST_SCAN,
    ST_FIND,
    ST_RESP
  } state_t;

endpackage

>>> sv/bba_split.sv
// ----------------------------------------------------------------------------
// bba_split
// Splits a block index into its group number and the bit inside the group,
// by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bba_split #(
  parameter int GROUP_SIZE = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [bba_pkg::IDX_W-1:0] dividend,
  output bba_pkg::split_t       result
);
  import bba_pkg::*;

  // quotient is exact for every index of IDX_W bits and group sizes up to 64
  localparam int                 SHIFT   = IDX_W + 7;
  localparam int                 PROD_W  = IDX_W + SHIFT;
  localparam logic [SHIFT-1:0]   RECIP   =
      SHIFT'((2 ** SHIFT + GROUP_SIZE - 1) / GROUP_SIZE);
  localparam logic [IDX_W-1:0]   DIVISOR = IDX_W'(GROUP_SIZE);

  logic                stage1;
  logic                stage2;
  logic                done;
  logic [IDX_W-1:0]    num;
  logic [IDX_W-1:0]    quo;
  logic [BITSEL_W-1:0] rem;
  logic [PROD_W-1:0]   prod;
  logic [IDX_W-1:0]    back;

  assign prod = PROD_W'(num) * PROD_W'(RECIP);
  assign back = quo * DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= go;
      stage2 <= stage1;
      done   <= stage2;
      if (go) begin
        num <= dividend;
      end
      if (stage1) begin
        quo <= prod[PROD_W-1:SHIFT];
      end
      // remainder from the registered quotient
      if (stage2) begin
        rem <= BITSEL_W'(num - back);
      end
    end
  end

  assign result.done    = done;
  assign result.group   = quo;
  assign result.bit_idx = rem;

endmodule

>>> sv/bitmap_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a used-block bitmap held in a group memory,
// with a running count of blocks in use.
// ----------------------------------------------------------------------------
//  channel   signals               handshake
//  request   req (kind, index)     taken when start is high and busy is low
//  response  rsp (index, status,   valid for one cycle while done is high,
//            used_count)           always taken
//
//  after reset a clearing pass writes every group to zero with busy high.
//  allocate scans the groups from group 0 and takes the first free block, or
//  answers full when the map has none; one group is read per cycle from the
//  single read port. free and mark go through a group/bit split, then a read
//  of the group and a write back when the bit changes; a bad request goes
//  straight to the response.
//  one item at a time; the receiver cannot stall the response.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS = 4096,
  parameter int GROUP_SIZE = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bba_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output bba_pkg::rsp_t rsp
);
  import bba_pkg::*;

  localparam int NUM_GROUPS = (NUM_BLOCKS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CW         = $clog2(NUM_BLOCKS + 1);
  localparam int BW         = $clog2(GROUP_SIZE);
  localparam int LAST_G     = NUM_GROUPS - 1;
  localparam int REM_BITS   = NUM_BLOCKS - LAST_G * GROUP_SIZE;
  localparam logic [GROUP_SIZE-1:0] LAST_MASK =
      {GROUP_SIZE{1'b1}} >> (GROUP_SIZE - REM_BITS);
  localparam logic [GW-1:0] LAST_ADDR = GW'(LAST_G);
  localparam logic [31:0]   NB32      = 32'(NUM_BLOCKS);

  state_t state, state_next;

  logic [GROUP_SIZE-1:0] mem [NUM_GROUPS];
  logic [GROUP_SIZE-1:0] rd_data;
  logic [GW-1:0]         rd_addr;
  logic                  wr_en;
  logic [GW-1:0]         wr_addr;
  logic [GROUP_SIZE-1:0] wr_data;

  req_t                  req_q;
  logic [CW-1:0]         cnt;
  logic [GW-1:0]         clr_grp;
  logic [GW-1:0]         issue_grp;
  logic                  issue_done;
  logic [GW-1:0]         chk_grp;
  logic                  chk_valid;
  logic [GROUP_SIZE-1:0] word;
  logic [GROUP_SIZE-1:0] freebits;
  logic [GW-1:0]         grp_q;
  logic [BW-1:0]         bit_q;
  rsp_t                  rsp_q;

  logic                  accept;
  logic                  in_range;
  logic                  go;
  split_t                split;
  logic [GROUP_SIZE-1:0] scan_free;
  logic                  hit;
  logic                  last_miss;
  logic [GROUP_SIZE-1:0] tgt_bit;
  logic                  used;
  logic                  upd_ok;
  logic [GROUP_SIZE-1:0] lowbit;
  logic [BW-1:0]         enc;
  logic [CW-1:0]         alloc_idx;

  bba_split #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_split (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .dividend(req.block_index),
    .result  (split)
  );

  // group memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign accept   = start && !busy;
  assign in_range = (32'(req.block_index) < NB32);
  assign go       = accept && (req.kind == KIND_FREE || req.kind == KIND_MARK) && in_range;

  assign scan_free = ~rd_data & ((chk_grp == LAST_ADDR) ? LAST_MASK : {GROUP_SIZE{1'b1}});
  assign hit       = chk_valid && (|scan_free);
  assign last_miss = chk_valid && !hit && (chk_grp == LAST_ADDR);

  assign tgt_bit = {{(GROUP_SIZE-1){1'b0}}, 1'b1} << bit_q;
  assign used    = |(rd_data & tgt_bit);
  assign upd_ok  = (req_q.kind == KIND_FREE) ? used : !used;

  // isolate the lowest free bit, then encode its position
  assign lowbit = freebits & (~freebits + 1'b1);
  always_comb begin
    enc = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (lowbit[i]) begin
        enc = enc | BW'(i);
      end
    end
  end
  assign alloc_idx = CW'(chk_grp) * CW'(GROUP_SIZE) + CW'(enc);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_grp == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (req.kind == KIND_ALLOC) state_next = ST_SCAN;
          else if (go)                state_next = ST_SPLIT;
          else                        state_next = ST_RESP;
        end
      end
      ST_SPLIT: begin
        if (split.done) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_RESP;
      ST_SCAN: begin
        if (hit)            state_next = ST_FIND;
        else if (last_miss) state_next = ST_RESP;
      end
      ST_FIND:  state_next = ST_RESP;
      ST_RESP:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr = grp_q;
    wr_en   = 1'b0;
    wr_addr = grp_q;
    wr_data = rd_data ^ tgt_bit;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_grp;
        wr_data = '0;
      end
      ST_SCAN: begin
        rd_addr = issue_grp;
      end
      ST_CHECK: begin
        wr_en = upd_ok;
      end
      ST_FIND: begin
        wr_en   = 1'b1;
        wr_addr = chk_grp;
        wr_data = word | lowbit;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_grp    <= '0;
      cnt        <= '0;
      chk_valid  <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          clr_grp <= clr_grp + 1'b1;
        end
        ST_IDLE: begin
          if (start) begin
            req_q                   <= req;
            issue_grp               <= '0;
            issue_done              <= 1'b0;
            chk_valid               <= 1'b0;
            rsp_q.granted_index     <= req.block_index;
            rsp_q.status            <= STATUS_BAD;
            rsp_q.used_count        <= COUNT_W'(cnt);
          end
        end
        ST_SPLIT: begin
          grp_q <= GW'(split.group);
          bit_q <= BW'(split.bit_idx);
        end
        ST_CHECK: begin
          if (upd_ok) begin
            rsp_q.status <= STATUS_OK;
            if (req_q.kind == KIND_FREE) begin
              cnt              <= cnt - 1'b1;
              rsp_q.used_count <= COUNT_W'(cnt - 1'b1);
            end else begin
              cnt              <= cnt + 1'b1;
              rsp_q.used_count <= COUNT_W'(cnt + 1'b1);
            end
          end
        end
        ST_SCAN: begin
          // one group issued per cycle, checked on the next; a hit keeps its group
          if (!hit) begin
            chk_grp <= issue_grp;
          end
          chk_valid <= !issue_done;
          if (!issue_done) begin
            if (issue_grp == LAST_ADDR) issue_done <= 1'b1;
            else                        issue_grp  <= issue_grp + 1'b1;
          end
          if (hit) begin
            word     <= rd_data;
            freebits <= scan_free;
          end else if (last_miss) begin
            rsp_q.granted_index <= '0;
            rsp_q.status        <= STATUS_FULL;
          end
        end
        ST_FIND: begin
          cnt                 <= cnt + 1'b1;
          rsp_q.granted_index <= IDX_W'(alloc_idx);
          rsp_q.status        <= STATUS_OK;
          rsp_q.used_count    <= COUNT_W'(cnt + 1'b1);
        end
        default: begin
          chk_valid <= 1'b0;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);
  assign rsp  = rsp_q;

endmodule

>>> tb/bitmap_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Self-checking bench for the first-fit block allocator. Requests go in
// through the start/busy handshake. A bitmap model in the bench predicts
// every response, and the responses are checked in order as they strobe out.
// Tests cover directed corner requests, random request mixes, and a run that
// fills the whole map.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int NUM_BLOCKS = 4096;
  localparam int GROUP_SIZE = 64;
  localparam int NUM_GROUPS = NUM_BLOCKS / GROUP_SIZE;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 4000;

  logic  clk;
  logic  rst;
  logic  start;
  req_t  req;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  // bench copy of the allocator state, bit set = block in use
  logic [GROUP_SIZE-1:0] used_map [NUM_GROUPS];
  logic [COUNT_W-1:0]    blocks_used;
  rsp_t                  expected_rsp [$];
  int                    mismatches;

  bitmap_block_allocator_core #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .GROUP_SIZE(GROUP_SIZE)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // apply one request to the bench bitmap and return the response it gives
  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    logic found;
    int   g;
    int   b;
    res.granted_index = r.block_index;
    res.status        = STATUS_BAD;
    g = r.block_index / GROUP_SIZE;
    b = r.block_index % GROUP_SIZE;
    case (r.kind)
      KIND_ALLOC: begin
        res.granted_index = '0;
        res.status        = STATUS_FULL;
        found             = 1'b0;
        for (int gi = 0; gi < NUM_GROUPS; gi++) begin
          for (int bi = 0; bi < GROUP_SIZE; bi++) begin
            if (!found && !used_map[gi][bi]) begin
              found              = 1'b1;
              used_map[gi][bi]   = 1'b1;
              blocks_used        = blocks_used + 1'b1;
              res.granted_index  = IDX_W'(gi * GROUP_SIZE + bi);
              res.status         = STATUS_OK;
            end
          end
        end
      end
      KIND_FREE: begin
        if (used_map[g][b]) begin
          used_map[g][b] = 1'b0;
          blocks_used    = blocks_used - 1'b1;
          res.status     = STATUS_OK;
        end
      end
      KIND_MARK: begin
        if (!used_map[g][b]) begin
          used_map[g][b] = 1'b1;
          blocks_used    = blocks_used + 1'b1;
          res.status     = STATUS_OK;
        end
      end
      default: ;
    endcase
    res.used_count = blocks_used;
    return res;
  endfunction

  // first block in use at or after a given index, wrapping around
  function automatic logic [IDX_W-1:0] pick_used(input logic [IDX_W-1:0] from);
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      idx = from + IDX_W'(i);
      if (used_map[idx / GROUP_SIZE][idx % GROUP_SIZE]) return idx;
    end
    return from;
  endfunction

  // start stays high across back-to-back items; the gap and drain tasks lower it
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [IDX_W-1:0] idx);
    req_t r;
    r.kind        = kind;
    r.block_index = idx;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    expected_rsp.push_back(apply_request(r));
  endtask

  task automatic sender_gap(input bit allow);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n    = 0;
    if (allow) begin
      if (pick >= 95) n = $urandom_range(20, 60);
      else if (pick >= 70) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold off new requests until every response is back
  task automatic drain;
    int waited;
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (expected_rsp.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_rsp.size() > 0) begin
      report($sformatf("%0d responses never arrived", expected_rsp.size()));
      expected_rsp.delete();
    end
  endtask

  task automatic test_basic_ops;
    send_item(KIND_ALLOC, 12'h000);
    send_item(KIND_ALLOC, 12'hfff);   // index ignored on allocate
    send_item(KIND_FREE, 12'h000);
    send_item(KIND_FREE, 12'h000);    // already free
    send_item(KIND_ALLOC, 12'h000);   // reuses the hole at 0
    send_item(KIND_MARK, 12'hfff);
    send_item(KIND_MARK, 12'hfff);    // already used
    send_item(KIND_FREE, 12'hfff);
    send_item(KIND_FREE, 12'hfff);
    send_item(KIND_MARK, 12'h03f);    // last bit of group 0
    send_item(KIND_MARK, 12'h040);    // first bit of group 1
    send_item(KIND_ALLOC, 12'h000);
    send_item(KIND_UNUSED, 12'hfff);
    send_item(KIND_UNUSED, 12'h000);
    send_item(KIND_UNUSED, 12'h555);
    send_item(KIND_FREE, 12'haaa);
    send_item(KIND_MARK, 12'haaa);
    send_item(KIND_FREE, 12'haaa);
    send_item(KIND_MARK, 12'h555);
    drain();
  endtask

  task automatic test_random_mix;
    int alloc_pct;
    int pick;
    bit gaps_on;
    logic [IDX_W-1:0] idx;
    for (int chunk = 0; chunk < 10; chunk++) begin
      alloc_pct = $urandom_range(20, 75);
      gaps_on   = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 99);
        idx  = IDX_W'($urandom);
        if (pick < alloc_pct) begin
          send_item(KIND_ALLOC, idx);
        end else if (pick < alloc_pct + (100 - alloc_pct) * 6 / 10) begin
          // mostly free blocks that are in use, sometimes free ones
          if ($urandom_range(0, 3) != 0) idx = pick_used(idx);
          send_item(KIND_FREE, idx);
        end else if (pick < 96) begin
          if ($urandom_range(0, 4) == 0) idx = pick_used(idx);
          send_item(KIND_MARK, idx);
        end else begin
          send_item(KIND_UNUSED, idx);
        end
        sender_gap(gaps_on);
      end
      if (chunk % 3 == 2) drain();
    end
    drain();
  endtask

  task automatic test_full_map;
    logic [IDX_W-1:0] idx;
    while (blocks_used < COUNT_W'(NUM_BLOCKS)) begin
      if ($urandom_range(0, 9) == 0) send_item(KIND_MARK, IDX_W'($urandom));
      else send_item(KIND_ALLOC, IDX_W'($urandom));
      sender_gap(1'($urandom_range(0, 1)));
    end
    send_item(KIND_ALLOC, 12'h000);   // nothing left
    send_item(KIND_ALLOC, 12'hfff);
    send_item(KIND_MARK, 12'h123);
    send_item(KIND_UNUSED, 12'h800);
    drain();
    for (int i = 0; i < 6; i++) begin
      idx = IDX_W'($urandom);
      send_item(KIND_FREE, idx);
      send_item(KIND_FREE, idx);
      sender_gap(1'b1);
    end
    send_item(KIND_FREE, 12'hfff);
    for (int i = 0; i < 8; i++) send_item(KIND_ALLOC, 12'h000);
    drain();
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report($sformatf("response with nothing outstanding: idx %0d st %0d cnt %0d",
                         rsp.granted_index, rsp.status, rsp.used_count));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.granted_index !== want.granted_index)
          report($sformatf("granted_index %0d, expected %0d",
                           rsp.granted_index, want.granted_index));
        if (rsp.status !== want.status)
          report($sformatf("status %0d, expected %0d", rsp.status, want.status));
        if (rsp.used_count !== want.used_count)
          report($sformatf("used_count %0d, expected %0d",
                           rsp.used_count, want.used_count));
      end
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    mismatches  = 0;
    blocks_used = '0;
    for (int g = 0; g < NUM_GROUPS; g++) used_map[g] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_random_mix();
    test_full_map();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[bitmap_block_allocator_core] OK");
    end else begin
      $display("[bitmap_block_allocator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("[bitmap_block_allocator_core] ERROR");
    $finish;
  end

endmodule

>>> bitmap_block_allocator_core.f
sv/bba_pkg.sv
sv/bba_split.sv
sv/bitmap_block_allocator_core.sv
tb/bitmap_block_allocator_core_tb.sv
